FILE: hdl/ulb_pkg.sv
`default_nettype none
package ulb_pkg;

    localparam int unsigned FUNC_W = 4;
    localparam int unsigned ID_W   = 6;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned POS_W  = 10;
    localparam int unsigned BYTE_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR = 4'd0,
        FN_COPY  = 4'd1,
        FN_INS   = 4'd2,
        FN_BKSP  = 4'd3,
        FN_DEL   = 4'd4,
        FN_LEFT  = 4'd5,
        FN_RIGHT = 4'd6,
        FN_HOME  = 4'd7,
        FN_END   = 4'd8,
        FN_READ  = 4'd9,
        FN_LOAD  = 4'd10
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   buffer_id;
        logic [ID_W-1:0]   source_id;
        logic [CP_W-1:0]   code_point;
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] load_byte;
        logic              load_first;
    } t_in_word;

    typedef struct packed {
        logic [POS_W-1:0]  length;
        logic [POS_W-1:0]  cursor;
        logic [BYTE_W-1:0] read_value;
        logic              status;
    } t_out_word;

    localparam logic [CP_W-1:0] CP_LIMIT = 21'h110000;

    // Byte count claimed by a lead byte; stray bytes count as one.
    function automatic logic [2:0] lead_size(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd1;
        if ((b & 8'hE0) == 8'hC0)      n = 3'd2;
        else if ((b & 8'hF0) == 8'hE0) n = 3'd3;
        else if ((b & 8'hF8) == 8'hF0) n = 3'd4;
        return n;
    endfunction

    function automatic logic [2:0] enc_size(input logic [CP_W-1:0] cp);
        logic [2:0] n;
        if (cp < 21'h80)         n = 3'd1;
        else if (cp < 21'h800)   n = 3'd2;
        else if (cp < 21'h10000) n = 3'd3;
        else                     n = 3'd4;
        return n;
    endfunction

    // Byte k of the UTF-8 encoding of cp.
    function automatic logic [7:0] enc_byte(input logic [CP_W-1:0] cp,
                                            input logic [1:0] k);
        logic [2:0] n;
        logic [7:0] b;
        n = enc_size(cp);
        b = 8'h00;
        unique case (n)
            3'd1: b = cp[7:0];
            3'd2: b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3: begin
                unique case (k)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                unique case (k)
                    2'd0: b = {5'b11110, cp[20:18]};
                    2'd1: b = {2'b10, cp[17:12]};
                    2'd2: b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/ulb_ram.sv
`default_nettype none
module ulb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/utf8_line_edit_buffers_top.sv
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in      | input     | i_in_valid/o_in_ready | t_in_word  (command word)
// out     | output    | o_out_valid/i_out_ready | t_out_word (result word)
//
// One command word at a time. A backspace or left cursor move adds up to 4
// reads to find the character start. Insert, delete, backspace and copy move
// bytes one at a time through the text memory (a read, then a write of that
// byte). Reset clears all lengths and cursors; the text memory is not
// cleared. A stalled result word holds in the output register until taken.
module utf8_line_edit_buffers_top
    import ulb_pkg::*;
#(
    parameter int unsigned BUFFER_COUNT = 32,
    parameter int unsigned BUFFER_BYTES = 1024
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_data
);
    localparam int unsigned ID_BITS  = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
    localparam int unsigned OFF_BITS = $clog2(BUFFER_BYTES);
    localparam int unsigned ADDR_W   = ID_BITS + OFF_BITS;
    localparam int unsigned LEN_W    = OFF_BITS + 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(BUFFER_BYTES - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DEC   = 8'b0000_0010,  // decode, issue first read if needed
        S_SCAN  = 8'b0000_0100,  // step cursor back over the found character
        S_RD    = 8'b0000_1000,  // issue read of source byte
        S_WR    = 8'b0001_0000,  // write byte read last cycle
        S_ENC   = 8'b0010_0000,  // write encoded bytes of insert
        S_WAIT  = 8'b0100_0000,  // memory read latency for probe
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    t_in_word r_cmd;

    logic [LEN_W-1:0] r_len [BUFFER_COUNT];
    logic [LEN_W-1:0] r_cur [BUFFER_COUNT];

    // Working registers.
    logic [LEN_W-1:0] r_wlen, n_wlen, r_wcur, n_wcur;
    logic [LEN_W-1:0] r_i, n_i;       // move index
    logic [LEN_W-1:0] r_end, n_end;   // move stop
    logic [2:0]       r_n, n_n;       // char size / step count
    logic [1:0]       r_k, n_k;
    logic             r_status, n_status;
    logic [7:0]       r_rv, n_rv;
    logic             r_ovalid;
    t_out_word        r_out;

    logic             m_we;
    logic [ADDR_W-1:0] m_waddr, m_raddr;
    logic [7:0]       m_wdata, m_rdata;

    ulb_ram #(.WIDTH(8), .DEPTH(2 ** ADDR_W)) u_text (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    logic id_ok, src_ok;
    logic [ID_BITS-1:0] tid, sid;
    assign id_ok  = 32'(r_cmd.buffer_id) < BUFFER_COUNT;
    assign src_ok = 32'(r_cmd.source_id) < BUFFER_COUNT;
    assign tid = r_cmd.buffer_id[ID_BITS-1:0];
    assign sid = r_cmd.source_id[ID_BITS-1:0];

    function automatic logic [ADDR_W-1:0] addr(input logic [ID_BITS-1:0] b,
                                               input logic [LEN_W-1:0] o);
        return {b, o[OFF_BITS-1:0]};
    endfunction

    assign o_in_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Move plan: copy bytes [r_i .. r_end) from read offset r_i+delta
    // Forward move (delete/backspace/copy): dst = r_i, src = r_i + r_n (or copy src).
    // Backward move (insert): dst = r_i - 1 + n, src = r_i - 1, counting down.
    logic [LEN_W-1:0] m_dst, m_src;
    logic is_ins;
    assign is_ins = (r_cmd.func == FN_INS);

    always_comb begin
        if (is_ins) begin
            m_src = r_i - LEN_W'(1);
            m_dst = r_i - LEN_W'(1) + LEN_W'(r_n);
        end else if (r_cmd.func == FN_COPY) begin
            m_src = r_i;
            m_dst = r_i;
        end else begin
            m_src = r_i + LEN_W'(r_n);
            m_dst = r_i;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_wlen   = r_wlen;
        n_wcur   = r_wcur;
        n_i      = r_i;
        n_end    = r_end;
        n_n      = r_n;
        n_k      = r_k;
        n_status = r_status;
        n_rv     = r_rv;
        m_we     = 1'b0;
        m_waddr  = addr(tid, m_dst);
        m_wdata  = m_rdata;
        m_raddr  = addr(tid, r_wcur);
        unique case (r_state)
            S_IDLE: begin
                // latch the word and fetch the target's length and cursor
                n_state = (i_in_valid && o_in_ready) ? S_DEC : S_IDLE;
            end
            S_DEC: begin
                n_status = 1'b1;
                n_rv     = 8'h00;
                n_n      = 3'd1;
                n_state  = S_DONE;
                if (id_ok) begin
                    priority case (r_cmd.func)
                        FN_CLEAR: begin
                            n_wlen = '0; n_wcur = '0; n_status = 1'b0;
                        end
                        FN_COPY: begin
                            if (src_ok) begin
                                n_wlen = r_len[sid]; n_wcur = r_len[sid];
                                n_status = 1'b0;
                                n_i = '0; n_end = r_len[sid];
                                if (sid != tid) n_state = S_RD;
                            end
                        end
                        FN_INS: begin
                            if (r_cmd.code_point < CP_LIMIT &&
                                (r_wlen + LEN_W'(enc_size(r_cmd.code_point))) <= MAX_LEN) begin
                                n_n = enc_size(r_cmd.code_point);
                                n_i = r_wlen; n_end = r_wcur;
                                n_k = '0;
                                n_status = 1'b0;
                                n_state = S_RD;
                            end
                        end
                        FN_BKSP, FN_LEFT: begin
                            if (r_wcur != '0) begin
                                n_status = 1'b0;
                                n_n = 3'd1;
                                m_raddr = addr(tid, r_wcur - LEN_W'(1));
                                n_state = (r_wcur - LEN_W'(1) == '0) ? S_SCAN : S_WAIT;
                                // when the step reaches position 0 stop at once
                                if (r_wcur - LEN_W'(1) == '0) n_n = 3'd1;
                            end
                        end
                        FN_DEL, FN_RIGHT: begin
                            if (r_wcur < r_wlen) begin
                                n_status = 1'b0;
                                m_raddr = addr(tid, r_wcur);
                                n_state = S_WAIT;
                            end
                        end
                        FN_HOME: begin n_wcur = '0; n_status = 1'b0; end
                        FN_END:  begin n_wcur = r_wlen; n_status = 1'b0; end
                        FN_READ: begin
                            if (32'(r_cmd.position) < 32'(r_wlen)) begin
                                n_status = 1'b0;
                                m_raddr = addr(tid, LEN_W'(r_cmd.position));
                                n_state = S_WAIT;
                            end
                        end
                        FN_LOAD: begin
                            n_wlen = r_cmd.load_first ? '0 : r_wlen;
                            if (n_wlen < MAX_LEN) begin
                                m_we = 1'b1;
                                m_waddr = addr(tid, n_wlen);
                                m_wdata = r_cmd.load_byte;
                                n_wlen = n_wlen + LEN_W'(1);
                                n_status = 1'b0;
                            end
                            n_wcur = n_wlen;
                        end
                        default: ;
                    endcase
                end
            end
            S_WAIT: begin
                // m_rdata holds the probed byte
                priority case (r_cmd.func)
                    FN_READ: begin
                        n_rv = m_rdata; n_state = S_DONE;
                    end
                    FN_DEL, FN_RIGHT: begin
                        n_n = lead_size(m_rdata);
                        if (LEN_W'(lead_size(m_rdata)) > r_wlen - r_wcur)
                            n_n = 3'(r_wlen - r_wcur);
                        if (r_cmd.func == FN_RIGHT) begin
                            n_wcur = r_wcur + LEN_W'(n_n);
                            n_state = S_DONE;
                        end else begin
                            n_i = r_wcur; n_end = r_wlen - LEN_W'(n_n);
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        // back scan: byte at cur - r_n was read
                        if (r_n < 3'd4 && m_rdata[7:6] == 2'b10 &&
                            r_wcur - LEN_W'(r_n) != '0) begin
                            n_n = r_n + 3'd1;
                            m_raddr = addr(tid, r_wcur - LEN_W'(r_n) - LEN_W'(1));
                            n_state = S_WAIT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                // r_n is the size of the preceding character
                n_wcur = r_wcur - LEN_W'(r_n);
                if (r_cmd.func == FN_LEFT) begin
                    n_state = S_DONE;
                end else begin
                    n_i = r_wcur - LEN_W'(r_n);
                    n_end = r_wlen - LEN_W'(r_n);
                    n_state = S_RD;
                end
            end
            S_RD: begin
                m_raddr = (r_cmd.func == FN_COPY) ? addr(sid, m_src) : addr(tid, m_src);
                if (is_ins ? (r_i > r_end) : (r_i < r_end)) begin
                    n_state = S_WR;
                end else if (is_ins) begin
                    n_state = S_ENC;
                end else begin
                    if (r_cmd.func == FN_DEL || r_cmd.func == FN_BKSP)
                        n_wlen = r_end;
                    n_state = S_DONE;
                end
            end
            S_WR: begin
                m_we = 1'b1;
                m_wdata = m_rdata;
                n_i = is_ins ? r_i - LEN_W'(1) : r_i + LEN_W'(1);
                n_state = S_RD;
            end
            S_ENC: begin
                m_we = 1'b1;
                m_waddr = addr(tid, r_wcur + LEN_W'(r_k));
                m_wdata = enc_byte(r_cmd.code_point, r_k);
                n_k = r_k + 2'd1;
                if (3'(r_k) + 3'd1 == r_n) begin
                    n_wlen = r_wlen + LEN_W'(r_n);
                    n_wcur = r_wcur + LEN_W'(r_n);
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int b = 0; b < BUFFER_COUNT; b++) begin
                r_len[b] <= '0;
                r_cur[b] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            if (r_state == S_DONE) begin
                r_ovalid <= 1'b1;
                if (id_ok) begin
                    r_len[tid] <= r_wlen;
                    r_cur[tid] <= r_wcur;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd  <= i_in_data;
            r_wlen <= r_len[i_in_data.buffer_id[ID_BITS-1:0]];
            r_wcur <= r_cur[i_in_data.buffer_id[ID_BITS-1:0]];
        end else begin
            r_wlen <= n_wlen;
            r_wcur <= n_wcur;
        end
        r_i      <= n_i;
        r_end    <= n_end;
        r_n      <= n_n;
        r_k      <= n_k;
        r_status <= n_status;
        r_rv     <= n_rv;
        if (r_state == S_DONE) begin
            r_out.length     <= id_ok ? POS_W'(r_wlen) : '0;
            r_out.cursor     <= id_ok ? POS_W'(r_wcur) : '0;
            r_out.read_value <= r_rv;
            r_out.status     <= r_status;
        end
    end
endmodule
`default_nettype wire
